// ----- design/mcid_pkg.sv -----
package mcid_pkg;

   // Channel count limits
   localparam int CHANNELS_MAX = 8;
   localparam int CHANNELS_DEFAULT = 8;

   // Field widths
   localparam int MASK_W = 8;
   localparam int COUNT_W = 8;
   localparam int PACKED_W = CHANNELS_MAX * COUNT_W;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRUE_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_COUNTS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVALS = 2'd3;

   // Debounced state of one channel
   typedef enum logic [1:0] {
      ST_FALSE = 2'd0,
      ST_TRUE = 2'd1,
      ST_UNDEF = 2'd2
   } deb_state_type;

   typedef struct packed {
      logic [MASK_W-1:0] pin_levels;
      logic [MASK_W-1:0] reinit_mask;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0] true_mask;
      logic [MASK_W-1:0] defined_mask;
   } rsp_payload_type;

   // Per-channel control from the top level
   typedef struct packed {
      logic update;
      logic enable;
      logic true_level;
      logic reinit;
      logic level;
   } ch_ctrl_type;

   // Per-channel report, taken from the state after this tick
   typedef struct packed {
      logic is_true;
      logic is_defined;
   } ch_status_type;

endpackage

// ----- design/multi_channel_input_debouncer.sv -----
// Debouncer for up to eight status pins. Each transfer on the req channel is one
// millisecond tick carrying the raw pin levels and a per-channel reinitialize mask;
// each tick yields exactly one rsp transfer with the debounced true and defined
// masks as they stand after that tick. One tick is taken every cycle unless req_stall
// holds it back while a held result is stalled on rsp; a tick passes through the
// input register, then all channels update side by side into the result register,
// whose content is offered on rsp. Configuration registers are written through the csr
// port, which is always ready, and should change only while no tick is in flight.
module multi_channel_input_debouncer
   import mcid_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PACKED_W-1:0]    csr_data
);

   logic [MASK_W-1:0]   enable_ff, enable_in;
   logic [MASK_W-1:0]   true_level_ff, true_level_in;
   logic [PACKED_W-1:0] confirm_ff, confirm_in;
   logic [PACKED_W-1:0] interval_ff, interval_in;

   logic                in_valid_ff, in_valid_in;
   req_payload_type     in_data_ff, in_data_in;
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_data_ff, out_data_in;

   logic                advance;
   logic                req_take;
   logic [MASK_W-1:0]   true_bits;
   logic [MASK_W-1:0]   defined_bits;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      enable_in = enable_ff;
      true_level_in = true_level_ff;
      confirm_in = confirm_ff;
      interval_in = interval_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE:   enable_in = csr_data[MASK_W-1:0];
            CSR_TRUE_LEVEL:       true_level_in = csr_data[MASK_W-1:0];
            CSR_CONFIRM_COUNTS:   confirm_in = csr_data;
            CSR_SAMPLE_INTERVALS: interval_in = csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow: the result register frees up when empty or taken
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Channels update on the cycle their tick moves to the result register
   for (genvar c = 0; c < CHANNELS_MAX; c++) begin : g_ch
      if (c < CHANNELS) begin : g_on
         ch_ctrl_type   ctrl;
         ch_status_type status;

         assign ctrl.update = in_valid_ff && advance;
         assign ctrl.enable = enable_ff[c];
         assign ctrl.true_level = true_level_ff[c];
         assign ctrl.reinit = in_data_ff.reinit_mask[c];
         assign ctrl.level = in_data_ff.pin_levels[c];

         mcid_channel u_channel (
            .clock           (clock),
            .reset           (reset),
            .ctrl            (ctrl),
            .confirm_count   (confirm_ff[c*COUNT_W +: COUNT_W]),
            .sample_interval (interval_ff[c*COUNT_W +: COUNT_W]),
            .status          (status)
         );

         assign true_bits[c] = status.is_true;
         assign defined_bits[c] = status.is_defined;
      end else begin : g_off
         assign true_bits[c] = 1'b0;
         assign defined_bits[c] = 1'b0;
      end
   end

   // Hold the result until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            out_data_in.true_mask = true_bits;
            out_data_in.defined_mask = defined_bits;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         true_level_ff <= '0;
         confirm_ff <= '0;
         interval_ff <= '0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         true_level_ff <= true_level_in;
         confirm_ff <= confirm_in;
         interval_ff <= interval_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ----- design/mcid_channel.sv -----
module mcid_channel
   import mcid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ch_ctrl_type        ctrl,
   input  logic [COUNT_W-1:0] confirm_count,
   input  logic [COUNT_W-1:0] sample_interval,
   output ch_status_type      status
);

   deb_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] run_ff, run_in;
   logic [COUNT_W-1:0] elapsed_ff, elapsed_in;
   logic               prev_valid_ff, prev_valid_in;
   logic               prev_level_ff, prev_level_in;

   logic [COUNT_W-1:0] elapsed_inc;
   logic [COUNT_W-1:0] run_inc;
   logic               cont;
   deb_state_type      next_state;

   // Saturating increments
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign run_inc = (run_ff == '1) ? run_ff : run_ff + 1'b1;

   // Decide whether the sample continues the run and where it leads
   always_comb begin
      cont = 1'b0;
      next_state = ST_FALSE;
      case (state_ff)
         ST_FALSE: begin
            cont = (ctrl.level == ctrl.true_level);
            next_state = ST_TRUE;
         end
         ST_TRUE: begin
            cont = (ctrl.level != ctrl.true_level);
            next_state = ST_FALSE;
         end
         default: begin
            cont = prev_valid_ff && (prev_level_ff == ctrl.level);
            next_state = (ctrl.level == ctrl.true_level) ? ST_TRUE : ST_FALSE;
         end
      endcase
   end

   // Advance the channel on each tick
   always_comb begin
      state_in = state_ff;
      run_in = run_ff;
      elapsed_in = elapsed_ff;
      prev_valid_in = prev_valid_ff;
      prev_level_in = prev_level_ff;
      if (ctrl.update) begin
         if (ctrl.reinit) begin
            state_in = ST_UNDEF;
            run_in = '0;
            elapsed_in = '0;
            prev_valid_in = 1'b0;
            prev_level_in = 1'b0;
         end else if (ctrl.enable) begin
            if (elapsed_inc >= sample_interval) begin
               elapsed_in = '0;
               prev_valid_in = 1'b1;
               prev_level_in = ctrl.level;
               if (cont) begin
                  if (run_inc >= confirm_count) begin
                     run_in = '0;
                     state_in = next_state;
                  end else begin
                     run_in = run_inc;
                  end
               end else begin
                  run_in = '0;
               end
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
      end
   end

   // Report from the updated state; a disabled channel reads settled false
   assign status.is_true = ctrl.enable && (state_in == ST_TRUE);
   assign status.is_defined = !ctrl.enable || (state_in == ST_TRUE) || (state_in == ST_FALSE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_UNDEF;
         run_ff <= '0;
         elapsed_ff <= '0;
         prev_valid_ff <= 1'b0;
         prev_level_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff <= run_in;
         elapsed_ff <= elapsed_in;
         prev_valid_ff <= prev_valid_in;
         prev_level_ff <= prev_level_in;
      end
   end

endmodule

// ----- dv/multi_channel_input_debouncer_tb.sv -----
`timescale 1ns / 1ps

module multi_channel_input_debouncer_tb;
   import mcid_pkg::*;

   localparam int NUM_CH = CHANNELS_DEFAULT;
   localparam int RESULT_LATENCY = 2;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [1:0] NO_SAMPLE = 2'd2;

   // Tracks the debounced state of every channel and the masks each tick should report
   class debounce_scoreboard;
      logic [MASK_W-1:0] ch_enable;
      logic [MASK_W-1:0] true_level;
      logic [PACKED_W-1:0] confirms;
      logic [PACKED_W-1:0] intervals;
      deb_state_type ch_state [NUM_CH];
      logic [COUNT_W-1:0] run_len [NUM_CH];
      logic [COUNT_W-1:0] elapsed [NUM_CH];
      logic [1:0] last_level [NUM_CH];
      rsp_payload_type expected_masks [$];
      int errors;
      int checked;

      function new();
         ch_enable = '0;
         true_level = '0;
         confirms = '0;
         intervals = '0;
         errors = 0;
         checked = 0;
         for (int c = 0; c < NUM_CH; c++) begin
            ch_state[c] = ST_UNDEF;
            run_len[c] = '0;
            elapsed[c] = '0;
            last_level[c] = NO_SAMPLE;
         end
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [PACKED_W-1:0] data);
         case (idx)
            CSR_CHANNEL_ENABLE: ch_enable = data[MASK_W-1:0];
            CSR_TRUE_LEVEL: true_level = data[MASK_W-1:0];
            CSR_CONFIRM_COUNTS: confirms = data;
            CSR_SAMPLE_INTERVALS: intervals = data;
            default: ;
         endcase
      endfunction

      // Advance every channel by one tick and queue the masks it leaves behind
      function void note_tick(req_payload_type t);
         rsp_payload_type r;
         logic lvl;
         logic cont;
         deb_state_type nxt;
         r = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            if (t.reinit_mask[c]) begin
               ch_state[c] = ST_UNDEF;
               run_len[c] = '0;
               elapsed[c] = '0;
               last_level[c] = NO_SAMPLE;
            end else if (ch_enable[c]) begin
               if (elapsed[c] != 8'hff)
                  elapsed[c] = elapsed[c] + 1'b1;
               if (elapsed[c] >= intervals[8*c +: 8]) begin
                  elapsed[c] = '0;
                  lvl = t.pin_levels[c];
                  // a settled channel counts disagreeing samples, an undefined one equal ones
                  case (ch_state[c])
                     ST_FALSE: begin
                        cont = (lvl == true_level[c]);
                        nxt = ST_TRUE;
                     end
                     ST_TRUE: begin
                        cont = (lvl != true_level[c]);
                        nxt = ST_FALSE;
                     end
                     default: begin
                        cont = (last_level[c] == {1'b0, lvl});
                        nxt = (lvl == true_level[c]) ? ST_TRUE : ST_FALSE;
                     end
                  endcase
                  if (cont) begin
                     if (run_len[c] != 8'hff)
                        run_len[c] = run_len[c] + 1'b1;
                     if (run_len[c] >= confirms[8*c +: 8]) begin
                        run_len[c] = '0;
                        ch_state[c] = nxt;
                     end
                  end else begin
                     run_len[c] = '0;
                  end
                  last_level[c] = {1'b0, lvl};
               end
            end
            // disabled channels read as settled false
            if (!ch_enable[c]) begin
               r.defined_mask[c] = 1'b1;
            end else if (ch_state[c] == ST_TRUE) begin
               r.true_mask[c] = 1'b1;
               r.defined_mask[c] = 1'b1;
            end else if (ch_state[c] == ST_FALSE) begin
               r.defined_mask[c] = 1'b1;
            end
         end
         expected_masks.push_back(r);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type exp;
         if (expected_masks.size() == 0) begin
            $error("unexpected result: true_mask %02h defined_mask %02h",
                   got.true_mask, got.defined_mask);
            errors++;
            return;
         end
         exp = expected_masks.pop_front();
         checked++;
         if (got.true_mask !== exp.true_mask) begin
            $error("true_mask: expected %02h, got %02h", exp.true_mask, got.true_mask);
            errors++;
         end
         if (got.defined_mask !== exp.defined_mask) begin
            $error("defined_mask: expected %02h, got %02h",
                   exp.defined_mask, got.defined_mask);
            errors++;
         end
      endfunction

      function int pending();
         return expected_masks.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [PACKED_W-1:0] csr_data = '0;

   debounce_scoreboard sb;
   logic steady = 1'b0;
   logic [MASK_W-1:0] held_levels = '0;
   int settings = 0;
   int cycle_count = 0;

   multi_channel_input_debouncer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Observe every transfer on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            sb.note_tick(req_payload);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_payload);
      end
   end

   function automatic int draw_wait();
      if (steady || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic chance(int odds);
      return odds != 0 && $urandom_range(0, odds - 1) == 0;
   endfunction

   task automatic drive_tick(input req_payload_type t);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
   endtask

   // Stall the result channel at random before transfers
   task automatic serve_results();
      int hold;
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   endtask

   // Drop valid and let every tick in flight drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 1) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [PACKED_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [MASK_W-1:0] en, input logic [MASK_W-1:0] tl,
                            input logic [PACKED_W-1:0] confirm,
                            input logic [PACKED_W-1:0] span);
      wait_idle();
      write_csr(CSR_CHANNEL_ENABLE, {{(PACKED_W-MASK_W){1'b0}}, en});
      write_csr(CSR_TRUE_LEVEL, {{(PACKED_W-MASK_W){1'b0}}, tl});
      write_csr(CSR_CONFIRM_COUNTS, confirm);
      write_csr(CSR_SAMPLE_INTERVALS, span);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Hold pin levels that toggle now and then, with glitches and reinitializes mixed in
   task automatic run_ticks(input int count, input int flip_odds, input int noise_odds,
                            input int reinit_odds);
      req_payload_type t;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         for (int c = 0; c < NUM_CH; c++)
            if (chance(flip_odds))
               held_levels[c] = ~held_levels[c];
         t.pin_levels = held_levels;
         if (chance(noise_odds))
            t.pin_levels = t.pin_levels ^ MASK_W'($urandom_range(0, 255));
         t.reinit_mask = chance(reinit_odds) ? MASK_W'($urandom_range(0, 255)) : '0;
         drive_tick(t);
      end
      steady = 1'b0;
   endtask

   initial begin
      logic [15:0] opening_ticks [10];
      logic [15:0] mixed_ticks [12];
      logic [MASK_W-1:0] en;
      logic [MASK_W-1:0] tl;
      logic [PACKED_W-1:0] confirm;
      logic [PACKED_W-1:0] span;

      opening_ticks = '{16'hff00, 16'hff00, 16'hff00, 16'h0000, 16'h0000,
                        16'h0000, 16'h5aa5, 16'h5a00, 16'h5a00, 16'ha500};
      mixed_ticks = '{16'hff00, 16'hff00, 16'h0000, 16'h0081, 16'h3c00, 16'h3c00,
                      16'h3c00, 16'hc300, 16'hc318, 16'hc300, 16'hff00, 16'h0000};

      sb = new();
      fork
         serve_results();
      join_none
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: every channel disabled, reinitialize hits disabled channels
      drive_tick(req_payload_type'(16'h0000));
      drive_tick(req_payload_type'(16'hffff));
      drive_tick(req_payload_type'(16'hff00));

      // Sample every tick, zero confirm count, mixed polarity
      configure(8'hff, 8'h0f, '0, '0);
      foreach (opening_ticks[i])
         drive_tick(req_payload_type'(opening_ticks[i]));

      // Two channels disabled, uneven intervals and confirm counts
      configure(8'h7e, 8'hc3, 64'h0302_0100_ff02_0103, 64'h0001_0203_0001_02ff);
      foreach (mixed_ticks[i])
         drive_tick(req_payload_type'(mixed_ticks[i]));

      // Long intervals and a full-length confirm run on quiet pins
      configure(8'hff, 8'h5a, 64'h0204_0102_0300_ff01, 64'h0100_0302_01ff_00ff);
      held_levels = MASK_W'($urandom_range(0, 255));
      run_ticks(600, 500, 0, 0);

      // Random settings, mostly short intervals and counts
      for (int k = 0; k < 8; k++) begin
         en = MASK_W'($urandom_range(0, 255));
         tl = MASK_W'($urandom_range(0, 255));
         for (int b = 0; b < CHANNELS_MAX; b++) begin
            confirm[8*b +: 8] = (k == 2) ? 8'($urandom_range(0, 255)) :
                                           8'($urandom_range(0, 4));
            span[8*b +: 8] = (k == 2) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 3));
         end
         if (k == 0) begin
            en = '0;
            tl = '0;
         end else if (k == 1) begin
            en = '1;
            tl = '1;
         end else if (k == 3) begin
            en = '1;
            confirm = '1;
            span = '0;
         end
         configure(en, tl, confirm, span);
         run_ticks(115, 12, 10, 25);
      end

      wait_idle();
      $display("Checked %0d tick results across %0d register settings",
               sb.checked, settings);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- multi_channel_input_debouncer.f -----
design/mcid_pkg.sv
design/mcid_channel.sv
design/multi_channel_input_debouncer.sv
dv/multi_channel_input_debouncer_tb.sv
